// ===== rtl/isdbt_bi_pkg.sv =====
// ----------------------------------------------------------------------------
// isdbt_bi_pkg
// shared types, register codes and branch tables for the bit interleaver
// ----------------------------------------------------------------------------
package isdbt_bi_pkg;

    // default build values
    localparam int MAX_DELAY_DEF = 65536;
    localparam int BRANCHES_DEF  = 6;

    // configuration port
    localparam int CFG_W = 4;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_CONSTELLATION = 2'd0;
    localparam logic [IDX_W-1:0] REG_TX_MODE       = 2'd1;
    localparam logic [IDX_W-1:0] REG_SEGMENT_COUNT = 2'd2;

    // constellation codes
    localparam logic [1:0] CST_QPSK  = 2'd0;
    localparam logic [1:0] CST_16QAM = 2'd1;
    localparam logic [1:0] CST_64QAM = 2'd2;

    // branch number width, enough for six branches
    localparam int BR_W = 3;

    // width of the unclamped delay arithmetic
    localparam int DF_W = 18;

    // branch tables
    localparam logic [6:0] TAB_QPSK  [2] = '{7'd1, 7'd120};
    localparam logic [6:0] TAB_16QAM [4] = '{7'd1, 7'd40, 7'd80, 7'd120};
    localparam logic [6:0] TAB_64QAM [6] = '{7'd1, 7'd24, 7'd48, 7'd72, 7'd96, 7'd120};

    // one bit handed from the sequencer to the delay memory
    typedef struct packed {
        logic            valid;
        logic            data;
        logic [BR_W-1:0] branch;
        logic            last;
    } bit_req_t;

    // one finished byte handed to the output queue
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_push_t;

    // branch count before the build limit
    function automatic logic [BR_W-1:0] nominal_branches(input logic [1:0] cst);
        logic [BR_W-1:0] nb;
        case (cst)
            CST_QPSK:  nb = 3'd2;
            CST_16QAM: nb = 3'd4;
            default:   nb = 3'd6;
        endcase
        return nb;
    endfunction

    // table entry for a branch, zero-based
    function automatic logic [6:0] tab_val(input logic [BR_W-1:0] nb,
                                           input logic [BR_W-1:0] k);
        logic [6:0] v;
        v = 7'd1;
        case (nb)
            3'd2:    v = (k < 3'd2) ? TAB_QPSK[k[0]] : TAB_QPSK[0];
            3'd4:    v = (k < 3'd4) ? TAB_16QAM[k[1:0]] : TAB_16QAM[0];
            default: v = (k < 3'd6) ? TAB_64QAM[k] : TAB_64QAM[0];
        endcase
        return v;
    endfunction

    // 384 times half the branch count
    function automatic logic [10:0] corr_unit(input logic [BR_W-1:0] nb);
        logic [10:0] u;
        case (nb)
            3'd2:    u = 11'd384;
            3'd4:    u = 11'd768;
            default: u = 11'd1152;
        endcase
        return u;
    endfunction

    // 120 times the branch count
    function automatic logic [9:0] corr_sub(input logic [BR_W-1:0] nb);
        logic [9:0] s;
        case (nb)
            3'd2:    s = 10'd240;
            3'd4:    s = 10'd480;
            default: s = 10'd720;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/isdbt_bit_interleaver_core.sv =====
// ----------------------------------------------------------------------------
// isdbt_bit_interleaver_core
// bit interleaver: bytes in, bits dealt over 2/4/6 delay branches, bytes out
// ----------------------------------------------------------------------------
// each input byte is split lsb first into eight bits, one bit per clock, and
// the next byte can enter while the last bit of the current one is still in
// flight. the rate is set by the single delay memory, which does one write and
// one read per bit. all branches share that memory, one region of MAX_DELAY
// bits per branch; each branch keeps a write pointer and a wrapped flag, and a
// read of a position not yet written since reset returns zero, so no clearing
// pass is needed after reset. up to two bytes may be in flight or waiting at
// the output; beyond that the input request is stalled. configuration is
// written through cfg_we / cfg_index / cfg_data; the user must write it only
// while idle, and the core itself does not enforce this.
// ----------------------------------------------------------------------------
module isdbt_bit_interleaver_core
    import isdbt_bi_pkg::*;
#(
    parameter int MAX_DELAY = MAX_DELAY_DEF,
    parameter int BRANCHES  = BRANCHES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    // input requests
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    // output requests
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte
);

    localparam int DW = $clog2(MAX_DELAY);

    // configuration registers
    logic [1:0] constellation_reg;
    logic [1:0] tx_mode_reg;
    logic [3:0] segment_count_reg;

    // bytes accepted and not yet delivered
    logic [1:0] inflight_reg, inflight_next;

    logic          feed_free;
    logic          in_take;
    logic          out_take;
    bit_req_t      req;
    logic [DW-1:0] delay;
    byte_push_t    push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            constellation_reg <= CST_QPSK;
            tx_mode_reg       <= 2'd1;
            segment_count_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CONSTELLATION: constellation_reg <= cfg_data[1:0];
                REG_TX_MODE:       tx_mode_reg       <= cfg_data[1:0];
                REG_SEGMENT_COUNT: segment_count_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // take a byte when the sequencer frees up and the output has room
    assign in_stall = !(feed_free && (inflight_reg < 2'd2));
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_take && !out_take)
        begin
            inflight_next = inflight_reg + 2'd1;
        end
        else if (!in_take && out_take)
        begin
            inflight_next = inflight_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // bit sequencer with branch select and delay
    isdbt_bi_feed #(
        .MAX_DELAY (MAX_DELAY),
        .BRANCHES  (BRANCHES)
    ) u_feed (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (in_take),
        .load_byte     (data_byte),
        .constellation (constellation_reg),
        .tx_mode       (tx_mode_reg),
        .segment_count (segment_count_reg),
        .free          (feed_free),
        .req           (req),
        .delay         (delay)
    );

    // delay lines in one memory, one write and one read per bit
    isdbt_bi_mem #(
        .MAX_DELAY (MAX_DELAY),
        .BRANCHES  (BRANCHES)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .delay (delay),
        .push  (push)
    );

    // output skid queue
    isdbt_bi_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte)
    );

endmodule

// ===== rtl/isdbt_bi_feed.sv =====
// ----------------------------------------------------------------------------
// isdbt_bi_feed
// bit sequencer: splits a byte into bits, picks the branch and its delay
// ----------------------------------------------------------------------------
module isdbt_bi_feed
    import isdbt_bi_pkg::*;
#(
    parameter int MAX_DELAY = MAX_DELAY_DEF,
    parameter int BRANCHES  = BRANCHES_DEF,
    localparam int DW       = $clog2(MAX_DELAY)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  logic [7:0]      load_byte,
    input  logic [1:0]      constellation,
    input  logic [1:0]      tx_mode,
    input  logic [3:0]      segment_count,
    output logic            free,
    output bit_req_t        req,
    output logic [DW-1:0]   delay
);

    logic [7:0]      byte_reg;
    logic [2:0]      bit_cnt_reg, bit_cnt_next;
    logic            active_reg, active_next;
    logic [BR_W-1:0] sel_reg, sel_next;
    bit_req_t        req_reg, req_next;
    logic [DW-1:0]   delay_reg, delay_next;

    logic [BR_W-1:0] nb_nom;
    logic [BR_W-1:0] nb;
    logic [BR_W-1:0] kk;
    logic [5:0]      prod;
    logic [DF_W-1:0] pos;
    logic [DF_W-1:0] sub;
    logic [DF_W-1:0] diff;
    logic            last_bit;

    assign last_bit = (bit_cnt_reg == 3'd7);
    assign free     = !active_reg || last_bit;

    // branch count limited to the built branches
    assign nb_nom = nominal_branches(constellation);
    assign nb     = (32'(nb_nom) > 32'(BRANCHES)) ? BR_W'(BRANCHES) : nb_nom;
    assign kk     = (sel_reg >= nb) ? '0 : sel_reg;

    // delay = tab[k] - 1 + mode*384*(nb_nom/2)*segments - 120*nb_nom, clamped
    assign prod = 6'(tx_mode) * 6'(segment_count);
    assign pos  = DF_W'(prod) * DF_W'(corr_unit(nb_nom)) + DF_W'(tab_val(nb_nom, kk))
                  - DF_W'(1);
    assign sub  = DF_W'(corr_sub(nb_nom));
    assign diff = pos - sub;

    always_comb
    begin
        if (pos < sub)
        begin
            delay_next = '0;
        end
        else if (32'(diff) > 32'(MAX_DELAY - 1))
        begin
            delay_next = DW'(MAX_DELAY - 1);
        end
        else
        begin
            delay_next = DW'(diff);
        end
    end

    always_comb
    begin
        active_next  = active_reg;
        bit_cnt_next = bit_cnt_reg;
        sel_next     = sel_reg;
        req_next     = '0;
        if (active_reg)
        begin
            req_next.valid  = 1'b1;
            req_next.data   = byte_reg[bit_cnt_reg];
            req_next.branch = kk;
            req_next.last   = last_bit;
            sel_next        = (kk + 3'd1 >= nb) ? '0 : kk + 3'd1;
            bit_cnt_next    = bit_cnt_reg + 3'd1;
            if (last_bit)
            begin
                active_next = 1'b0;
            end
        end
        if (load)
        begin
            active_next  = 1'b1;
            bit_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            bit_cnt_reg <= '0;
            sel_reg     <= '0;
            req_reg     <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            bit_cnt_reg <= bit_cnt_next;
            sel_reg     <= sel_next;
            req_reg     <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= load_byte;
        end
        delay_reg <= delay_next;
    end

    assign req   = req_reg;
    assign delay = delay_reg;

endmodule

// ===== rtl/isdbt_bi_mem.sv =====
// ----------------------------------------------------------------------------
// isdbt_bi_mem
// delay line memory: per-branch write pointers, bit store, byte collector
// ----------------------------------------------------------------------------
module isdbt_bi_mem
    import isdbt_bi_pkg::*;
#(
    parameter int MAX_DELAY = MAX_DELAY_DEF,
    parameter int BRANCHES  = BRANCHES_DEF,
    localparam int DW       = $clog2(MAX_DELAY),
    localparam int KW       = $clog2(BRANCHES),
    localparam int DEPTH    = BRANCHES * MAX_DELAY,
    localparam int AW       = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  bit_req_t      req,
    input  logic [DW-1:0] delay,
    output byte_push_t    push
);

    logic mem [DEPTH];

    logic [DW-1:0] ptr_reg  [BRANCHES];
    logic          wrap_reg [BRANCHES];

    logic          s3_valid_reg;
    logic          s3_last_reg;
    logic          s3_fwd_reg;
    logic          s3_ok_reg;
    logic          s3_bit_reg;
    logic          rdata_reg;
    logic [7:0]    collect_reg;

    logic [KW-1:0] k;
    logic [DW-1:0] wp;
    logic [DW-1:0] rp;
    logic [DW-1:0] wp_inc;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic          fill_ok;
    logic          bit_out;

    assign k  = req.branch[KW-1:0];
    assign wp = ptr_reg[k];

    // read position trails the write position by the delay, modulo the line
    assign rp = (wp >= delay) ? (wp - delay)
              : DW'(({1'b0, wp} + (DW+1)'(MAX_DELAY)) - {1'b0, delay});

    assign wp_inc = (32'(wp) == 32'(MAX_DELAY - 1)) ? '0 : wp + DW'(1);

    // entries never written read as zero
    assign fill_ok = wrap_reg[k] || (delay <= wp);

    assign waddr = AW'(k) * AW'(MAX_DELAY) + AW'(wp);
    assign raddr = AW'(k) * AW'(MAX_DELAY) + AW'(rp);

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            mem[waddr] <= req.data;
            rdata_reg  <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BRANCHES; i++)
            begin
                ptr_reg[i]  <= '0;
                wrap_reg[i] <= 1'b0;
            end
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= req.valid;
            if (req.valid)
            begin
                ptr_reg[k] <= wp_inc;
                if (32'(wp) == 32'(MAX_DELAY - 1))
                begin
                    wrap_reg[k] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s3_last_reg <= req.last;
        s3_fwd_reg  <= (delay == '0);
        s3_ok_reg   <= fill_ok;
        s3_bit_reg  <= req.data;
        if (s3_valid_reg)
        begin
            collect_reg <= {bit_out, collect_reg[7:1]};
        end
    end

    // zero delay passes the bit straight through
    assign bit_out = s3_fwd_reg ? s3_bit_reg : (s3_ok_reg & rdata_reg);

    assign push.valid = s3_valid_reg && s3_last_reg;
    assign push.data  = {bit_out, collect_reg[7:1]};

endmodule

// ===== rtl/isdbt_bi_obuf.sv =====
// ----------------------------------------------------------------------------
// isdbt_bi_obuf
// two-entry output queue
// ----------------------------------------------------------------------------
module isdbt_bi_obuf
    import isdbt_bi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  byte_push_t push,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte
);

    logic [7:0] data_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       take;

    assign out_valid = (count_reg != 2'd0);
    assign out_byte  = data_reg[rd_ptr_reg];
    assign take      = out_valid && !out_stall;

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push.valid && take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push.valid)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            data_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

// ===== dv/tb_isdbt_bit_interleaver_core.sv =====
// ----------------------------------------------------------------------------
// tb_isdbt_bit_interleaver_core
// self-checking bench for the isdbt bit interleaver core
// ----------------------------------------------------------------------------
// bytes are pushed through the input channel under several register settings.
// a local model of the branch delay lines predicts every output byte, and each
// output is checked in order. idling comes in random bursts on both sides. the
// run also holds the output for a long stretch, pauses the input until the core
// drains, and ends with a phase that has no idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_isdbt_bit_interleaver_core;
    import isdbt_bi_pkg::*;

    // register codes outside the nominal range
    localparam logic [1:0]       CST_CODE3  = 2'd3;
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int DEPTH = MAX_DELAY_DEF;

    // dut ports
    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic [7:0]       data_byte;
    logic             out_valid;
    logic             out_stall;
    logic [7:0]       out_byte;

    // mirror of the register file, reset values
    logic [1:0]       cst_q  = CST_QPSK;
    logic [1:0]       mode_q = 2'd1;
    logic [3:0]       seg_q  = 4'd1;

    // mirror of the delay lines, one circular bit store per branch
    bit               branch_bits [BRANCHES_DEF][DEPTH];
    int               branch_wp [BRANCHES_DEF];
    int               next_branch;

    // output bytes still owed by the core, ring with the oldest at owed_rd
    logic [7:0]       expected_bytes [64];
    logic [5:0]       owed_wr;
    logic [5:0]       owed_rd;
    int               owed_count;

    int               err_count;
    int               bytes_sent;
    int               bytes_seen;
    int               settings_used;
    bit               gaps_on;
    int               hold_request;

    isdbt_bit_interleaver_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte)
    );

    // 125 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // model of the interleaver
    // ------------------------------------------------------------------------

    // branch count for the current constellation, code three acts as 64qam
    function automatic int branch_count();
        int nb;
        case (cst_q)
            CST_QPSK:  nb = 2;
            CST_16QAM: nb = 4;
            default:   nb = 6;
        endcase
        if (nb > BRANCHES_DEF)
            nb = BRANCHES_DEF;
        return nb;
    endfunction

    // delay of branch k in uses of that branch, clamped to the store
    function automatic int branch_lag(int k, int nb);
        int base;
        int corr;
        int d;
        if (k >= nb)
            k = 0;
        // tables step by 120/(nb-1) after the leading 1
        case (nb)
            2:       base = (k == 0) ? 1 : 120;
            4:       base = (k == 0) ? 1 : 40 * k;
            default: base = (k == 0) ? 1 : 24 * k;
        endcase
        corr = int'(mode_q) * 384 * (nb / 2) * int'(seg_q) - 120 * nb;
        d = base - 1 + corr;
        // zero mode or zero segments drives this negative: straight through
        if (d < 0)
            d = 0;
        if (d > DEPTH - 1)
            d = DEPTH - 1;
        return d;
    endfunction

    // push eight bits lsb first through the branches, collect what leaves
    function automatic logic [7:0] interleave_byte(logic [7:0] din);
        int nb;
        int k;
        int wp;
        int rp;
        int d;
        logic [7:0] res;
        nb = branch_count();
        res = '0;
        for (int j = 0; j < 8; j++)
        begin
            // select may be past the end after a constellation change
            if (next_branch >= nb)
                next_branch = 0;
            k = next_branch;
            wp = branch_wp[k];
            if (wp >= DEPTH)
                wp = 0;
            d = branch_lag(k, nb);
            branch_bits[k][wp] = din[j];
            rp = (wp + DEPTH - d) % DEPTH;
            res[j] = branch_bits[k][rp];
            branch_wp[k] = (wp + 1 == DEPTH) ? 0 : wp + 1;
            next_branch = (k + 1 >= nb) ? 0 : k + 1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // shared helpers
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    // offer one byte, optionally after a random gap, and wait for acceptance
    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        // inputs only move at rising edges, so the falling edge shows what the
        // next rising edge will see
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
        end
        @(posedge clk);
        expected_bytes[owed_wr] = interleave_byte(b);
        owed_wr = owed_wr + 6'd1;
        owed_count++;
        bytes_sent++;
    endtask

    // stop offering and wait until every owed byte has come out
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (owed_count != 0)
            @(posedge clk);
    endtask

    // drained, plus an idle margin before returning
    task automatic wait_idle();
        wait_drain();
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CONSTELLATION: cst_q  = val[1:0];
            REG_TX_MODE:       mode_q = val[1:0];
            REG_SEGMENT_COUNT: seg_q  = val;
            default:           ;
        endcase
        @(posedge clk);
    endtask

    task automatic reconfigure(input logic [1:0] cst, input logic [1:0] mode,
                               input logic [3:0] seg);
        wait_idle();
        write_reg(REG_CONSTELLATION, {2'b00, cst});
        write_reg(REG_TX_MODE, {2'b00, mode});
        write_reg(REG_SEGMENT_COUNT, seg);
        settings_used++;
    endtask

    task automatic send_random(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 15);
            // mostly random bytes, now and then the all-zero and all-one bytes
            if (r == 0)
                send_byte(8'h00);
            else if (r == 1)
                send_byte(8'hFF);
            else
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // output side: random stall bursts and the long hold
    // ------------------------------------------------------------------------
    initial
    begin : out_stall_gen
        int burst_left;
        burst_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            // a long hold counted here in cycles, the sender keeps going
            if (hold_request > 0)
            begin
                burst_left = hold_request;
                hold_request = 0;
            end
            if (burst_left > 0)
            begin
                out_stall <= 1'b1;
                burst_left--;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                burst_left = $urandom_range(1, 19) - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // result check, one output request per accepting edge
    // ------------------------------------------------------------------------
    initial
    begin : result_check
        logic [7:0] want;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (out_valid && !out_stall)
            begin
                bytes_seen++;
                if (owed_count == 0)
                    report_mismatch($sformatf("unexpected output byte %h", out_byte));
                else
                begin
                    want = expected_bytes[owed_rd];
                    owed_rd = owed_rd + 6'd1;
                    owed_count--;
                    if (out_byte !== want)
                        report_mismatch($sformatf("out_byte %h, expected %h (result %0d)",
                                                  out_byte, want, bytes_seen));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset settings, extremes and single bits
    task automatic test_reset_defaults();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'hA5);
        send_byte(8'h5A);
    endtask

    // mode zero makes every delay negative, so bits pass straight through
    task automatic test_zero_delay();
        reconfigure(CST_QPSK, 2'd0, 4'd1);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h3C);
        send_byte(8'hC3);
    endtask

    // constellation code three behaves as 64qam, unused index is dropped
    task automatic test_code_three();
        reconfigure(CST_CODE3, 2'd0, 4'd1);
        send_byte(8'h96);
        send_byte(8'h69);
        send_byte(8'hF0);
        wait_idle();
        write_reg(REG_UNUSED, 4'hF);
        // 40 bits leave the select on branch four
        send_byte(8'h0F);
        send_byte(8'hE7);
    endtask

    // zero segments, and 16qam entered with the select past its branch count
    task automatic test_zero_segments();
        reconfigure(CST_16QAM, 2'd1, 4'd0);
        send_byte(8'h81);
        send_byte(8'h7E);
        send_byte(8'hC9);
    endtask

    // random bytes across a spread of settings, history kept between them
    task automatic test_random_sweep();
        logic [1:0] csts [5];
        logic [1:0] modes [5];
        logic [3:0] segs [5];
        csts  = '{CST_QPSK, CST_16QAM, CST_64QAM, CST_64QAM, CST_16QAM};
        modes = '{2'd1, 2'd1, 2'd1, 2'd2, 2'd3};
        segs  = '{4'd1, 4'd1, 4'd1, 4'd2, 4'd1};
        for (int s = 0; s < 5; s++)
        begin
            reconfigure(csts[s], modes[s], segs[s]);
            send_random(130);
        end
    endtask

    // output held for a long stretch so the core fills and stalls its input
    task automatic test_output_hold();
        reconfigure(CST_QPSK, 2'd1, 4'd1);
        hold_request = 300;
        send_random(60);
    endtask

    // sender stops mid-phase until every owed byte has come out
    task automatic test_sender_pause();
        reconfigure(CST_16QAM, 2'd2, 4'd3);
        send_random(30);
        wait_drain();
        send_random(30);
    endtask

    // mode three delays at 13 segments in 64qam, and the widest segment code
    task automatic test_max_settings();
        reconfigure(CST_64QAM, 2'd3, 4'd13);
        send_random(40);
        reconfigure(CST_QPSK, 2'd3, 4'd15);
        send_random(40);
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_streaming();
        reconfigure(CST_QPSK, 2'd1, 4'd1);
        gaps_on = 1'b0;
        send_random(250);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_seq
        err_count     = 0;
        bytes_sent    = 0;
        bytes_seen    = 0;
        settings_used = 1;
        gaps_on       = 1'b1;
        hold_request  = 0;
        next_branch   = 0;
        owed_wr       = '0;
        owed_rd       = '0;
        owed_count    = 0;
        for (int k = 0; k < BRANCHES_DEF; k++)
            branch_wp[k] = 0;

        rst_n      = 1'b0;
        in_valid  <= 1'b0;
        data_byte <= 8'h00;
        cfg_we    <= 1'b0;
        cfg_index <= REG_CONSTELLATION;
        cfg_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_zero_delay();
        test_code_three();
        test_zero_segments();
        test_random_sweep();
        test_output_hold();
        test_sender_pause();
        test_max_settings();
        test_streaming();

        // bounded drain, then a quiet stretch to catch stray outputs
        in_valid <= 1'b0;
        for (int c = 0; c < 5000 && owed_count != 0; c++)
            @(posedge clk);
        repeat (32) @(posedge clk);
        if (owed_count != 0)
            report_mismatch($sformatf("%0d output bytes never arrived", owed_count));

        $display("covered %0d bytes in, %0d bytes out, %0d register settings",
                 bytes_sent, bytes_seen, settings_used);
        $display("incl. zero delay, code three, unused index, zero segments, long hold, drain");
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/isdbt_bi_pkg.sv
rtl/isdbt_bi_feed.sv
rtl/isdbt_bi_mem.sv
rtl/isdbt_bi_obuf.sv
rtl/isdbt_bit_interleaver_core.sv
dv/tb_isdbt_bit_interleaver_core.sv
